FILE: design/pixel_color_filter_assert.svh
// assertion macros for the pixel color filter checker
`ifndef PIXEL_COLOR_FILTER_ASSERT_SVH
`define PIXEL_COLOR_FILTER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PCF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pixel_color_filter check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PCF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pixel_color_filter check failed");

`endif

FILE: design/pcf_pkg.sv
`timescale 1ns / 1ps

package pcf_pkg;

    typedef enum logic [2:0] {
        MODE_POSTERIZE = 3'd0,
        MODE_NEGATIVE  = 3'd1,
        MODE_SEPIA     = 3'd2,
        MODE_GREY      = 3'd3,
        MODE_PASS      = 3'd4
    } mode_t;

    typedef struct packed {
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
        logic [7:0] alpha_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
        logic [7:0] alpha_out;
    } pixel_out_t;

    localparam int unsigned NUM_CHAN = 3;
    localparam int unsigned SUM_W    = 19;
    localparam int unsigned Q0_W     = 10;

    // lane order: blue, green, red; columns: red, green, blue weights in thousandths
    localparam logic [9:0] SEPIA_K [NUM_CHAN][NUM_CHAN] = '{
        '{10'd272, 10'd534, 10'd131},
        '{10'd349, 10'd686, 10'd168},
        '{10'd389, 10'd769, 10'd189}
    };

    localparam logic [10:0] DIV1000_MUL = 11'd1048;
    localparam logic [9:0]  DIV3_MUL    = 10'd683;
    localparam logic [5:0]  DIV25_MUL   = 6'd41;
    localparam logic [9:0]  THOUSAND    = 10'd1000;
    localparam logic [4:0]  POST_STEP   = 5'd25;
    localparam logic [7:0]  CHAN_MAX    = 8'd255;

endpackage

FILE: design/pixel_color_filter.sv
`timescale 1ns / 1ps
// pixel color filter: one BGRA pixel in, one filtered BGRA pixel out.
// input channel in_valid / in_ready / in_data, output channel out_valid /
// out_ready / out_data; a transfer happens when valid and ready are both high.
// cfg_we / cfg_data write the filter mode (0 posterize, 1 negative, 2 sepia,
// 3 grey, other codes pass the pixel through); write only while the pipe is
// empty. the mode is sampled with each pixel as it enters.
// four register stages: input capture, sepia products and sums, reciprocal
// multiplies, correction, saturation and mode select into the output register.
// a pixel moves from the input capture register through the sums and
// multiply registers into out_data, held in place while the receiver stalls.
// throughput: one pixel per clock unless stalled; every stage holds one pixel.
// reset (rst_n low, asynchronous) empties the pipe and sets the mode to
// pass through.
// when out_valid is high and out_ready low the whole pipe holds and in_ready
// drops; nothing is lost or repeated. alpha always passes unchanged.
module pixel_color_filter
    import pcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  pixel_in_t  in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output pixel_out_t out_data
);

    mode_t mode_reg;
    logic  advance;

    logic       valid_s1_reg;
    mode_t      mode_s1_reg;
    logic [7:0] chan_s1_reg [NUM_CHAN];
    logic [7:0] alpha_s1_reg;

    logic             valid_s2_reg;
    mode_t            mode_s2_reg;
    logic [7:0]       chan_s2_reg [NUM_CHAN];
    logic [7:0]       alpha_s2_reg;
    logic [SUM_W-1:0] sep_sum_s2_reg [NUM_CHAN];
    logic [SUM_W-1:0] sep_sum_s2_next [NUM_CHAN];
    logic [9:0]       grey_sum_s2_reg;
    logic [9:0]       grey_sum_s2_next;
    logic [3:0]       post_q_s2_reg [NUM_CHAN];
    logic [3:0]       post_q_s2_next [NUM_CHAN];

    logic             valid_s3_reg;
    mode_t            mode_s3_reg;
    logic [7:0]       chan_s3_reg [NUM_CHAN];
    logic [7:0]       alpha_s3_reg;
    logic [SUM_W-1:0] sep_sum_s3_reg [NUM_CHAN];
    logic [Q0_W-1:0]  sep_q0_s3_reg [NUM_CHAN];
    logic [Q0_W-1:0]  sep_q0_s3_next [NUM_CHAN];
    logic [7:0]       grey_s3_reg;
    logic [7:0]       grey_s3_next;
    logic [7:0]       post_s3_reg [NUM_CHAN];
    logic [7:0]       post_s3_next [NUM_CHAN];

    logic       out_valid_reg;
    pixel_out_t out_reg;
    pixel_out_t out_next;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_PASS;
            valid_s1_reg  <= 1'b0;
            valid_s2_reg  <= 1'b0;
            valid_s3_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= mode_t'(cfg_data);
            end
            if (advance)
            begin
                valid_s1_reg  <= in_valid;
                valid_s2_reg  <= valid_s1_reg;
                valid_s3_reg  <= valid_s2_reg;
                out_valid_reg <= valid_s3_reg;
            end
        end
    end

    // sepia sums, grey sum, posterize quotients
    always_comb
    begin
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            sep_sum_s2_next[i] = SUM_W'(chan_s1_reg[2]) * SUM_W'(SEPIA_K[i][0])
                               + SUM_W'(chan_s1_reg[1]) * SUM_W'(SEPIA_K[i][1])
                               + SUM_W'(chan_s1_reg[0]) * SUM_W'(SEPIA_K[i][2]);
            post_q_s2_next[i]  = 4'((14'(chan_s1_reg[i]) * 14'(DIV25_MUL)) >> 10);
        end
        grey_sum_s2_next = 10'(chan_s1_reg[0]) + 10'(chan_s1_reg[1]) + 10'(chan_s1_reg[2]);
    end

    // reciprocal multiplies, posterize step multiply
    always_comb
    begin
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            sep_q0_s3_next[i] = Q0_W'((30'(sep_sum_s2_reg[i]) * 30'(DIV1000_MUL)) >> 20);
            post_s3_next[i]   = 8'(post_q_s2_reg[i]) * 8'(POST_STEP);
        end
        grey_s3_next = 8'((20'(grey_sum_s2_reg) * 20'(DIV3_MUL)) >> 11);
    end

    // sepia correction and saturation, mode select
    always_comb
    begin
        logic [SUM_W-1:0] rem;
        logic [Q0_W-1:0]  q;
        logic [7:0]       sep_sat [NUM_CHAN];
        logic [7:0]       res [NUM_CHAN];
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            rem = sep_sum_s3_reg[i] - SUM_W'(SUM_W'(sep_q0_s3_reg[i]) * SUM_W'(THOUSAND));
            q   = sep_q0_s3_reg[i] + Q0_W'(rem >= SUM_W'(THOUSAND));
            sep_sat[i] = (q > Q0_W'(CHAN_MAX)) ? CHAN_MAX : q[7:0];
            case (mode_s3_reg)
                MODE_POSTERIZE: res[i] = post_s3_reg[i];
                MODE_NEGATIVE:  res[i] = ~chan_s3_reg[i];
                MODE_SEPIA:     res[i] = sep_sat[i];
                MODE_GREY:      res[i] = grey_s3_reg;
                default:        res[i] = chan_s3_reg[i];
            endcase
        end
        out_next.blue_out  = res[0];
        out_next.green_out = res[1];
        out_next.red_out   = res[2];
        out_next.alpha_out = alpha_s3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mode_s1_reg    <= mode_reg;
            chan_s1_reg[0] <= in_data.blue_in;
            chan_s1_reg[1] <= in_data.green_in;
            chan_s1_reg[2] <= in_data.red_in;
            alpha_s1_reg   <= in_data.alpha_in;

            mode_s2_reg     <= mode_s1_reg;
            chan_s2_reg     <= chan_s1_reg;
            alpha_s2_reg    <= alpha_s1_reg;
            sep_sum_s2_reg  <= sep_sum_s2_next;
            grey_sum_s2_reg <= grey_sum_s2_next;
            post_q_s2_reg   <= post_q_s2_next;

            mode_s3_reg    <= mode_s2_reg;
            chan_s3_reg    <= chan_s2_reg;
            alpha_s3_reg   <= alpha_s2_reg;
            sep_sum_s3_reg <= sep_sum_s2_reg;
            sep_q0_s3_reg  <= sep_q0_s3_next;
            grey_s3_reg    <= grey_s3_next;
            post_s3_reg    <= post_s3_next;

            out_reg <= out_next;
        end
    end

endmodule

FILE: design/pcf_checker.sv
`timescale 1ns / 1ps
`include "pixel_color_filter_assert.svh"
module pcf_checker
    import pcf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_we,
    input logic [2:0] cfg_data,
    input logic       in_valid,
    input logic       in_ready,
    input pixel_in_t  in_data,
    input logic       out_valid,
    input logic       out_ready,
    input pixel_out_t out_data
);

    `PCF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    `PCF_ASSERT_IMP(a_stall_blocks_input, out_valid && !out_ready, !in_ready)
    `PCF_ASSERT_IMP(a_free_output_takes, !out_valid, in_ready)
    `PCF_ASSERT_NXT(a_alpha_passes,
        in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready,
        out_valid && (out_data.alpha_out == $past(in_data.alpha_in, 4)))

endmodule

bind pixel_color_filter pcf_checker u_pcf_checker (.*);
